// ===== rtl/lkvc_pkg.sv =====
// Package: sizes, operation codes and shared types of the LRU key/value cache.
`default_nettype none

package lkvc_pkg;

	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;
	localparam int SLOT_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int COUNT_BITS = $clog2(ENTRIES + 1);
	localparam int CFG_BITS   = 5;

	localparam logic [CFG_BITS-1:0] CAPACITY_RESET = CFG_BITS'(16);

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef logic [KEY_BITS-1:0]   key_t;
	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [SLOT_BITS-1:0]  slot_t;
	typedef logic [SLOT_BITS-1:0]  rank_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [CFG_BITS-1:0]   cfg_t;

	typedef struct packed {
		op_t    op;
		key_t   key;
		value_t value;
	} req_t;

	typedef struct packed {
		logic  hit;
		slot_t slot;
		rank_t rank;
	} match_t;

	typedef struct packed {
		logic   hit;
		value_t value_out;
		logic   evicted;
		key_t   evicted_key;
		value_t evicted_value;
		count_t entries_in_use;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/lkvc_ifs.sv =====
// Interfaces: request and response channels of the LRU key/value cache.
`default_nettype none

interface lkvc_req_if import lkvc_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	key_t       key;
	value_t     value;

	modport source(output valid, operation, key, value, input ready);
	modport sink(input valid, operation, key, value, output ready);
endinterface

interface lkvc_rsp_if import lkvc_pkg::*; ();
	logic   valid;
	logic   ready;
	logic   hit;
	value_t value_out;
	logic   evicted;
	key_t   evicted_key;
	value_t evicted_value;
	count_t entries_in_use;

	modport source(output valid, hit, value_out, evicted, evicted_key, evicted_value,
		entries_in_use, input ready);
	modport sink(input valid, hit, value_out, evicted, evicted_key, evicted_value,
		entries_in_use, output ready);
endinterface

`default_nettype wire

// ===== rtl/lkvc_match.sv =====
// Parallel key compare over all entries with a priority encoder for the hit slot.
`default_nettype none

module lkvc_match import lkvc_pkg::*; (
	input  logic [ENTRIES-1:0] entry_valid,
	input  key_t               key_store    [ENTRIES],
	input  rank_t              recency_rank [ENTRIES],
	input  key_t               key,
	output match_t             lookup
);

	// keys are unique among valid entries; lowest slot wins anyway
	always_comb begin
		lookup = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (entry_valid[i] && key_store[i] == key) begin
				lookup.hit  = 1'b1;
				lookup.slot = slot_t'(i);
				lookup.rank = recency_rank[i];
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lkvc_store.sv =====
// Entry state (keys, values, valid bits, recency ranks, count) and its update per item.
`default_nettype none

module lkvc_store import lkvc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  req_t               req,
	input  cfg_t               capacity,
	input  match_t             lookup,
	output logic [ENTRIES-1:0] entry_valid,
	output key_t               key_store    [ENTRIES],
	output rank_t              recency_rank [ENTRIES],
	output result_t            result
);

	key_t               key_store_q [ENTRIES];
	value_t             value_store [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	rank_t              rank_q [ENTRIES];
	count_t             count_q;

	logic [ENTRIES-1:0] valid_n;
	rank_t              rank_n [ENTRIES];
	count_t             count_n;

	count_t             cap_eff;
	count_t             cap_m1;
	rank_t              oldest;
	logic               do_evict;
	logic [ENTRIES-1:0] evict_mask;
	slot_t              evict_slot;
	slot_t              free_slot;
	slot_t              rd_slot;
	value_t             rd_value;
	key_t               rd_key;
	logic               key_wr;
	logic               val_wr;
	slot_t              wr_slot;

	assign entry_valid  = valid_q;
	assign key_store    = key_store_q;
	assign recency_rank = rank_q;

	// capacity 0 acts as 1, anything above the store size as the store size
	always_comb begin
		if (capacity == '0) begin
			cap_eff = count_t'(1);
		end else if (int'(capacity) > ENTRIES) begin
			cap_eff = count_t'(ENTRIES);
		end else begin
			cap_eff = count_t'(capacity);
		end
	end

	assign cap_m1   = cap_eff - count_t'(1);
	assign oldest   = rank_t'(count_q - count_t'(1));
	assign do_evict = (req.op == OP_INSERT) && !lookup.hit && (count_q >= cap_eff);

	always_comb begin
		evict_slot = '0;
		free_slot  = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			evict_mask[i] = do_evict && valid_q[i] && (count_t'(rank_q[i]) >= cap_m1);
			if (valid_q[i] && rank_q[i] == oldest) begin
				evict_slot = slot_t'(i);
			end
			if (!valid_q[i] || evict_mask[i]) begin
				free_slot = slot_t'(i);
			end
		end
	end

	assign rd_slot  = (req.op == OP_LOOKUP) ? lookup.slot : evict_slot;
	assign rd_value = value_store[rd_slot];
	assign rd_key   = key_store_q[evict_slot];

	always_comb begin
		valid_n = valid_q;
		rank_n  = rank_q;
		count_n = count_q;
		key_wr  = 1'b0;
		val_wr  = 1'b0;
		wr_slot = lookup.slot;
		unique case (req.op)
			OP_LOOKUP, OP_INSERT: begin
				if (lookup.hit) begin
					// promote: everything more recent than the hit ages by one
					for (int i = 0; i < ENTRIES; i++) begin
						if (valid_q[i] && rank_q[i] < lookup.rank) begin
							rank_n[i] = rank_q[i] + rank_t'(1);
						end
					end
					rank_n[lookup.slot] = '0;
					val_wr = (req.op == OP_INSERT);
				end else if (req.op == OP_INSERT) begin
					for (int i = 0; i < ENTRIES; i++) begin
						if (evict_mask[i]) begin
							valid_n[i] = 1'b0;
							rank_n[i]  = '0;
						end else if (valid_q[i]) begin
							rank_n[i] = rank_q[i] + rank_t'(1);
						end
					end
					valid_n[free_slot] = 1'b1;
					rank_n[free_slot]  = '0;
					key_wr  = 1'b1;
					val_wr  = 1'b1;
					wr_slot = free_slot;
					count_n = (do_evict ? cap_m1 : count_q) + count_t'(1);
				end
			end
			OP_REMOVE: begin
				if (lookup.hit) begin
					for (int i = 0; i < ENTRIES; i++) begin
						if (valid_q[i] && rank_q[i] > lookup.rank) begin
							rank_n[i] = rank_q[i] - rank_t'(1);
						end
					end
					valid_n[lookup.slot] = 1'b0;
					rank_n[lookup.slot]  = '0;
					if (count_q != '0) begin
						count_n = count_q - count_t'(1);
					end
				end
			end
			OP_CLEAR: begin
				valid_n = '0;
				for (int i = 0; i < ENTRIES; i++) begin
					rank_n[i] = '0;
				end
				count_n = '0;
			end
		endcase
	end

	always_comb begin
		result                = '0;
		result.hit            = lookup.hit && (req.op != OP_CLEAR);
		result.value_out      = (req.op == OP_LOOKUP && lookup.hit) ? rd_value : '0;
		result.evicted        = do_evict;
		result.evicted_key    = do_evict ? rd_key : '0;
		result.evicted_value  = do_evict ? rd_value : '0;
		result.entries_in_use = count_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (fire) begin
			valid_q <= valid_n;
			rank_q  <= rank_n;
			count_q <= count_n;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && key_wr) begin
			key_store_q[wr_slot] <= req.key;
		end
		if (fire && val_wr) begin
			value_store[wr_slot] <= req.value;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lru_key_value_cache_top.sv =====
// Top level: input register, capacity register, entry state and result register.
//
//  channel  | dir | handshake    | payload
//  ---------+-----+--------------+--------------------------------------------
//  req      | in  | valid/ready  | operation, key, value
//  rsp      | out | valid/ready  | hit, value_out, evicted, evicted_key,
//           |     |              | evicted_value, entries_in_use
//  cfg      | in  | cfg_we       | cfg_data = capacity_in_use
//
// One item per cycle sustained while rsp is not stalled; an accepted item sits
// in the input register for one pass of compare and rank update, then lands in
// the result register, where its result is valid. Reset empties the store and
// sets capacity to 16. A stalled rsp holds the result and the item waiting in
// the input register; req.ready drops only while both are occupied and rsp is
// stalled.
`default_nettype none

module lru_key_value_cache_top import lkvc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	lkvc_req_if.sink      req,
	lkvc_rsp_if.source    rsp,
	input  logic          cfg_we,
	input  cfg_t          cfg_data
);

	logic               valid_s1;
	req_t               req_s1;
	logic               rsp_valid_q;
	result_t            result_q;
	cfg_t               capacity_q;
	logic               advance;

	logic [ENTRIES-1:0] entry_valid;
	key_t               key_store    [ENTRIES];
	rank_t              recency_rank [ENTRIES];
	match_t             lookup;
	result_t            result;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	lkvc_match u_match (
		.entry_valid  (entry_valid),
		.key_store    (key_store),
		.recency_rank (recency_rank),
		.key          (req_s1.key),
		.lookup       (lookup)
	);

	lkvc_store u_store (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (advance),
		.req          (req_s1),
		.capacity     (capacity_q),
		.lookup       (lookup),
		.entry_valid  (entry_valid),
		.key_store    (key_store),
		.recency_rank (recency_rank),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			capacity_q  <= CAPACITY_RESET;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				capacity_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1.op    <= op_t'(req.operation);
			req_s1.key   <= req.key;
			req_s1.value <= req.value;
		end
		if (advance) begin
			result_q <= result;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.hit            = result_q.hit;
	assign rsp.value_out      = result_q.value_out;
	assign rsp.evicted        = result_q.evicted;
	assign rsp.evicted_key    = result_q.evicted_key;
	assign rsp.evicted_value  = result_q.evicted_value;
	assign rsp.entries_in_use = result_q.entries_in_use;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (int'(rsp.entries_in_use) <= ENTRIES))
		else $error("entry count above store size");

	a_evict_only_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.evicted) |-> !rsp.hit)
		else $error("eviction reported together with a hit");

	a_advance_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp.valid)
		else $error("processed item produced no result");

	a_no_accept_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && rsp_valid_q && !rsp.ready) |-> !req.ready)
		else $error("item accepted while both stages are held");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Testbench of the LRU key/value cache: random and directed requests checked against a predictor.
`timescale 1ns / 1ps

module testbench import lkvc_pkg::*; ();

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int POOL_SIZE      = 20;
	localparam int PHASE_ITEMS    = 215;
	localparam int DRAIN_CYCLES   = 8;

	// Shadow copy of the cache: predicts each response and checks it on arrival.
	class lru_tracker;
		key_t        keys[ENTRIES];
		value_t      vals[ENTRIES];
		bit          used[ENTRIES];
		int unsigned rank[ENTRIES];
		int unsigned count;
		int unsigned capacity;
		result_t     expected[$];
		int          errors;

		function new();
			foreach (used[i]) begin
				keys[i] = '0;
				vals[i] = '0;
				used[i] = 1'b0;
				rank[i] = 0;
			end
			count    = 0;
			capacity = CAPACITY_RESET;
			errors   = 0;
		endfunction

		function void set_capacity(cfg_t c);
			capacity = c;
		endfunction

		function int pending();
			return expected.size();
		endfunction

		function int find_slot(key_t k);
			for (int i = 0; i < ENTRIES; i++)
				if (used[i] && keys[i] == k)
					return i;
			return -1;
		endfunction

		function void promote(int slot);
			int unsigned r;
			r = rank[slot];
			for (int i = 0; i < ENTRIES; i++)
				if (used[i] && rank[i] < r)
					rank[i]++;
			rank[slot] = 0;
		endfunction

		function void note_request(op_t op, key_t k, value_t v);
			result_t     r;
			int          slot;
			int unsigned cap;
			int unsigned oldest;
			int unsigned gone;
			bit          placed;
			r    = '0;
			slot = find_slot(k);
			case (op)
				OP_LOOKUP: begin
					if (slot >= 0) begin
						r.hit       = 1'b1;
						r.value_out = vals[slot];
						promote(slot);
					end
				end
				OP_INSERT: begin
					if (slot >= 0) begin
						r.hit      = 1'b1;
						vals[slot] = v;
						promote(slot);
					end else begin
						cap = (capacity < 1) ? 1 : (capacity > ENTRIES) ? ENTRIES : capacity;
						// a lowered capacity drops every surplus entry at once
						if (count >= cap) begin
							oldest    = count - 1;
							r.evicted = 1'b1;
							for (int i = 0; i < ENTRIES; i++) begin
								if (used[i] && rank[i] >= cap - 1) begin
									if (rank[i] == oldest) begin
										r.evicted_key   = keys[i];
										r.evicted_value = vals[i];
									end
									used[i] = 1'b0;
									rank[i] = 0;
								end
							end
							count = cap - 1;
						end
						for (int i = 0; i < ENTRIES; i++)
							if (used[i])
								rank[i]++;
						placed = 1'b0;
						for (int i = 0; i < ENTRIES; i++) begin
							if (!placed && !used[i]) begin
								used[i] = 1'b1;
								keys[i] = k;
								vals[i] = v;
								rank[i] = 0;
								count++;
								placed  = 1'b1;
							end
						end
					end
				end
				OP_REMOVE: begin
					if (slot >= 0) begin
						r.hit = 1'b1;
						gone  = rank[slot];
						for (int i = 0; i < ENTRIES; i++)
							if (used[i] && rank[i] > gone)
								rank[i]--;
						used[slot] = 1'b0;
						rank[slot] = 0;
						if (count > 0)
							count--;
					end
				end
				default: begin
					foreach (used[i]) begin
						used[i] = 1'b0;
						rank[i] = 0;
					end
					count = 0;
				end
			endcase
			r.entries_in_use = count_t'(count);
			expected.push_back(r);
		endfunction

		task report(string msg);
			$display("%0t ERROR %s", $time, msg);
			errors++;
		endtask

		task check_response(result_t got);
			result_t want;
			if (expected.size() == 0) begin
				report("response with nothing expected");
				return;
			end
			want = expected.pop_front();
			if (got.hit !== want.hit)
				report($sformatf("hit: expected %0b got %0b", want.hit, got.hit));
			if (got.value_out !== want.value_out)
				report($sformatf("value_out: expected %h got %h", want.value_out, got.value_out));
			if (got.evicted !== want.evicted)
				report($sformatf("evicted: expected %0b got %0b", want.evicted, got.evicted));
			if (got.evicted_key !== want.evicted_key)
				report($sformatf("evicted_key: expected %h got %h",
					want.evicted_key, got.evicted_key));
			if (got.evicted_value !== want.evicted_value)
				report($sformatf("evicted_value: expected %h got %h",
					want.evicted_value, got.evicted_value));
			if (got.entries_in_use !== want.entries_in_use)
				report($sformatf("entries_in_use: expected %0d got %0d",
					want.entries_in_use, got.entries_in_use));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	cfg_t cfg_data;

	lkvc_req_if req_ch();
	lkvc_rsp_if rsp_ch();

	lru_tracker sb = new();

	bit          no_idle = 1'b0;
	int unsigned idle_cycles = 0;
	int unsigned rsp_hold = 0;
	key_t        key_pool[POOL_SIZE];

	lru_key_value_cache_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (no_idle || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	task automatic send_request(op_t op, key_t k, value_t v);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.operation <= op;
		req_ch.key       <= k;
		req_ch.value     <= v;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		sb.note_request(op, k, v);
	endtask

	// only while the cache is empty of work
	task automatic set_capacity(cfg_t c);
		req_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_capacity(c);
	endtask

	task automatic send_random();
		int unsigned r;
		op_t         op;
		key_t        k;
		r = $urandom_range(99);
		if (r < 42)
			op = OP_INSERT;
		else if (r < 77)
			op = OP_LOOKUP;
		else if (r < 97)
			op = OP_REMOVE;
		else
			op = OP_CLEAR;
		if ($urandom_range(9) == 0)
			k = $urandom;
		else
			k = key_pool[$urandom_range(POOL_SIZE - 1)];
		send_request(op, k, $urandom);
	endtask

	// response side: random backpressure
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_hold != 0) begin
				rsp_ch.ready <= 1'b0;
				rsp_hold--;
			end else begin
				rsp_ch.ready <= 1'b1;
				rsp_hold = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
			sb.check_response(result_t'{rsp_ch.hit, rsp_ch.value_out, rsp_ch.evicted,
				rsp_ch.evicted_key, rsp_ch.evicted_value, rsp_ch.entries_in_use});
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("testbench failed");
				$finish;
			end
		end
	end

	initial begin
		cfg_t caps[6];
		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_data         <= '0;
		req_ch.valid     <= 1'b0;
		req_ch.operation <= OP_LOOKUP;
		req_ch.key       <= '0;
		req_ch.value     <= '0;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: misses, extremes, update, remove, clear
		send_request(OP_LOOKUP, '0, '0);
		send_request(OP_REMOVE, '1, '0);
		send_request(OP_INSERT, '0, '0);
		send_request(OP_INSERT, '1, '1);
		send_request(OP_LOOKUP, '1, '0);
		send_request(OP_INSERT, '0, '1);
		send_request(OP_LOOKUP, '0, '1);
		send_request(OP_REMOVE, '1, '0);
		send_request(OP_CLEAR, '1, '1);
		send_request(OP_LOOKUP, '0, '0);

		// zero capacity behaves as one
		set_capacity(cfg_t'(0));
		send_request(OP_INSERT, 32'h1, 32'hA5A5_A5A5);
		send_request(OP_INSERT, 32'h2, 32'h5A5A_5A5A);

		// above range behaves as full size; then shrink below the count
		set_capacity('1);
		for (int i = 3; i <= 6; i++)
			send_request(OP_INSERT, key_t'(i), value_t'(32'h100 + i));
		send_request(OP_LOOKUP, 32'h2, '0);
		set_capacity(cfg_t'(2));
		send_request(OP_LOOKUP, 32'h3, '0);
		send_request(OP_INSERT, 32'h7, 32'h107);
		send_request(OP_REMOVE, 32'h3, '0);
		send_request(OP_CLEAR, '0, '0);

		caps[0] = cfg_t'(ENTRIES);
		caps[1] = cfg_t'(1);
		caps[2] = cfg_t'(0);
		caps[3] = '1;
		caps[4] = cfg_t'(3);
		caps[5] = cfg_t'($urandom_range(ENTRIES, 1));
		foreach (caps[p]) begin
			set_capacity(caps[p]);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				no_idle = (i % 100) < 25;
				send_random();
			end
		end
		no_idle = 1'b0;
		req_ch.valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
